### design/assert_macros.svh
// assertion macros used by the codec design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check outside reset
`define ARGC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check on every edge, reset included
`define ARGC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ARGC_ASSERT(lbl, prop, msg)
`define ARGC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/argc_pkg.sv
package argc_pkg;

   // sizes
   localparam int SYMBOLS         = 256;
   localparam int SYM_BITS        = $clog2(SYMBOLS);
   localparam int COUNT_BITS      = 32;
   localparam int VALUE_BITS      = 9;
   localparam int LEN_BITS        = 5;
   localparam int RUN_BITS        = 4;
   localparam int RUN_MAX         = 15;
   localparam int VALUE_ZEROS_MAX = 8;

   // operation and result kind codes
   localparam logic OP_ENCODE   = 1'b0;
   localparam logic OP_DECODE   = 1'b1;
   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [VALUE_BITS-1:0] symbol_in;
      logic                  code_bit;
   } req_type;

   typedef struct packed {
      logic                  result_kind;
      logic [VALUE_BITS-1:0] code_value;
      logic [LEN_BITS-1:0]   code_length;
      logic [VALUE_BITS-1:0] decoded_symbol;
      logic                  decode_error;
   } rsp_type;

   // control broadcast to every rank cell
   typedef struct packed {
      logic                  cmp;
      logic                  wr;
      logic [COUNT_BITS-1:0] cnt;
      logic [SYM_BITS-1:0]   to;
      logic [SYM_BITS-1:0]   from;
   } cell_ctl_type;

   // gamma codeword length 2L-1 of a value
   function automatic logic [LEN_BITS-1:0] gamma_len(input logic [VALUE_BITS-1:0] v);
      logic [RUN_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (v[i]) n = RUN_BITS'(i + 1);
      end
      return {n, 1'b0} - LEN_BITS'(1);
   endfunction

   // index of the single set bit of a one-hot vector
   function automatic logic [SYM_BITS-1:0] first_index(input logic [SYMBOLS-1:0] oh);
      logic [SYM_BITS-1:0] idx;
      idx = '0;
      for (int i = 0; i < SYMBOLS; i++) begin
         if (oh[i]) idx = idx | SYM_BITS'(i);
      end
      return idx;
   endfunction

endpackage

### design/argc_ram.sv
module argc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/argc_cell.sv
module argc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [argc_pkg::SYM_BITS-1:0] cell_index,
   input  argc_pkg::cell_ctl_type        ctl,
   input  logic                          lt_prev,
   output logic                          lt,
   output logic                          first
);

   logic [argc_pkg::COUNT_BITS-1:0] count_ff;
   logic                            lt_ff;

   // count of the symbol at this rank, and whether it is below the broadcast count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lt_ff    <= 1'b0;
      end else begin
         if (ctl.cmp) lt_ff <= (count_ff < ctl.cnt);
         if (ctl.wr) begin
            if (cell_index == ctl.to) begin
               count_ff <= ctl.cnt;
            end else if (cell_index == ctl.from) begin
               count_ff <= ctl.cnt - argc_pkg::COUNT_BITS'(1);
            end
         end
      end
   end

   // counts fall along the row, so the first lower cell is found from the neighbour
   assign lt    = lt_ff;
   assign first = lt_ff & ~lt_prev;

endmodule

### design/adaptive_rank_gamma_codec.sv
// Adaptive rank gamma codec.
// req channel: one word per item, operation 0 encodes symbol_in (1..256),
// operation 1 feeds one code bit to the gamma parser. rsp channel: at most
// one word per item, an encoded codeword or a decoded symbol / decode error.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Items are handled one at a time. A code bit that does not finish a code, an
// illegal symbol and a decode error are dealt with in the idle state alone. For an
// encode or a finished decode the rank update reads the count memory, compares
// the new count in every cell of the rank row, encodes the first lower cell and
// then does two write passes on the rank and symbol memories, which have a single
// write port; a saturated count leaves the list as it is and skips these passes.
// A decode error word is registered at the edge that takes the final code bit;
// an encode word or a decoded symbol is registered at the edge after the taking edge.
// The word then sits in an output register until the receiver takes it.
// After reset a clearing pass over all 256 entries loads the rank tables and zeroes
// the counts; req_stall is high during it. While rsp_stall holds a waiting
// result, no new request is taken.
`include "assert_macros.svh"

module adaptive_rank_gamma_codec (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  argc_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output argc_pkg::rsp_type rsp_word
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DSYM  = 4'd2;
   localparam logic [3:0] ST_LOOK  = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_PICK  = 4'd5;
   localparam logic [3:0] ST_MOVE  = 4'd6;
   localparam logic [3:0] ST_SWAP1 = 4'd7;
   localparam logic [3:0] ST_SWAP2 = 4'd8;

   localparam logic [1:0] PH_ZEROS = 2'd0;
   localparam logic [1:0] PH_VALUE = 2'd1;
   localparam logic [1:0] PH_WIDE  = 2'd2;

   localparam int SB = argc_pkg::SYM_BITS;
   localparam int CB = argc_pkg::COUNT_BITS;
   localparam int VB = argc_pkg::VALUE_BITS;
   localparam int RB = argc_pkg::RUN_BITS;

   logic [3:0]    state_ff, state_in;
   logic [SB-1:0] clr_ff, clr_in;
   logic [1:0]    phase_ff, phase_in;
   logic [RB-1:0] run_ff, run_in;
   logic [VB-1:0] acc_ff, acc_in;
   logic          enc_ff, enc_in;
   logic [SB-1:0] sym_ff, sym_in;
   logic [SB-1:0] from_ff, from_in;
   logic [SB-1:0] to_ff, to_in;
   logic [SB-1:0] other_ff, other_in;
   logic [CB-1:0] c_ff, c_in;
   logic          any_ff, any_in;
   logic [VB-1:0] val_ff, val_in;
   logic          rsp_valid_ff, rsp_valid_in;
   argc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept, emit;

   // memory ports
   logic          rank_wr_en, sym_wr_en, cnt_wr_en;
   logic [SB-1:0] rank_wr_addr, sym_wr_addr, cnt_wr_addr;
   logic [SB-1:0] rank_wr_data, sym_wr_data;
   logic [CB-1:0] cnt_wr_data;
   logic [SB-1:0] rank_rd_addr, sym_rd_addr, cnt_rd_addr;
   logic [SB-1:0] rank_rd_data, sym_rd_data;
   logic [CB-1:0] cnt_rd_data;

   // rank row
   argc_pkg::cell_ctl_type      cell_ctl;
   logic [argc_pkg::SYMBOLS-1:0] lt, first;

   argc_ram #(.WIDTH(SB), .DEPTH(argc_pkg::SYMBOLS)) u_rank_ram (
      .clock(clock), .wr_en(rank_wr_en), .wr_addr(rank_wr_addr), .wr_data(rank_wr_data),
      .rd_addr(rank_rd_addr), .rd_data(rank_rd_data));

   argc_ram #(.WIDTH(SB), .DEPTH(argc_pkg::SYMBOLS)) u_sym_ram (
      .clock(clock), .wr_en(sym_wr_en), .wr_addr(sym_wr_addr), .wr_data(sym_wr_data),
      .rd_addr(sym_rd_addr), .rd_data(sym_rd_data));

   argc_ram #(.WIDTH(CB), .DEPTH(argc_pkg::SYMBOLS)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_wr_en), .wr_addr(cnt_wr_addr), .wr_data(cnt_wr_data),
      .rd_addr(cnt_rd_addr), .rd_data(cnt_rd_data));

   // one cell per rank, each looking at its upper neighbour
   for (genvar j = 0; j < argc_pkg::SYMBOLS; j++) begin : g_cell
      if (j == 0) begin : g_head
         argc_cell u_cell (
            .clock(clock), .reset(reset), .cell_index(SB'(j)), .ctl(cell_ctl),
            .lt_prev(1'b0), .lt(lt[j]), .first(first[j]));
      end else begin : g_body
         argc_cell u_cell (
            .clock(clock), .reset(reset), .cell_index(SB'(j)), .ctl(cell_ctl),
            .lt_prev(lt[j-1]), .lt(lt[j]), .first(first[j]));
      end
   end

   assign req_stall = ~((state_ff == ST_IDLE) && (~rsp_valid_ff || ~rsp_stall));
   assign accept    = req_valid & ~req_stall;

   // sequencer, gamma parser and result formatting
   always_comb begin
      logic          fin, fin_wide;
      logic [VB-1:0] fin_val, acc_n;
      logic [RB-1:0] run_n;
      logic [CB-1:0] cnt_next;

      fin      = 1'b0;
      fin_wide = 1'b0;
      fin_val  = '0;
      acc_n    = {acc_ff[VB-2:0], req_word.code_bit};
      run_n    = run_ff - RB'(1);
      cnt_next = (cnt_rd_data == {CB{1'b1}}) ? cnt_rd_data : cnt_rd_data + CB'(1);

      state_in = state_ff;
      clr_in   = clr_ff;
      phase_in = phase_ff;
      run_in   = run_ff;
      acc_in   = acc_ff;
      enc_in   = enc_ff;
      sym_in   = sym_ff;
      from_in  = from_ff;
      to_in    = to_ff;
      other_in = other_ff;
      c_in     = c_ff;
      any_in   = any_ff;
      val_in   = val_ff;
      emit     = 1'b0;
      rsp_data_in = rsp_data_ff;

      rank_wr_en = 1'b0; rank_wr_addr = sym_ff;  rank_wr_data = to_ff;
      sym_wr_en  = 1'b0; sym_wr_addr  = to_ff;   sym_wr_data  = sym_ff;
      cnt_wr_en  = 1'b0; cnt_wr_addr  = sym_ff;  cnt_wr_data  = c_ff;
      rank_rd_addr = '0;
      sym_rd_addr  = '0;
      cnt_rd_addr  = '0;

      cell_ctl.cmp  = 1'b0;
      cell_ctl.wr   = 1'b0;
      cell_ctl.cnt  = c_ff;
      cell_ctl.to   = to_ff;
      cell_ctl.from = from_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            rank_wr_en = 1'b1; rank_wr_addr = clr_ff; rank_wr_data = clr_ff;
            sym_wr_en  = 1'b1; sym_wr_addr  = clr_ff; sym_wr_data  = clr_ff;
            cnt_wr_en  = 1'b1; cnt_wr_addr  = clr_ff; cnt_wr_data  = '0;
            clr_in = clr_ff + SB'(1);
            if (clr_ff == SB'(argc_pkg::SYMBOLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_word.operation == argc_pkg::OP_ENCODE) begin
                  if ((req_word.symbol_in != '0) &&
                      ({1'b0, req_word.symbol_in} <= (VB+1)'(argc_pkg::SYMBOLS))) begin
                     sym_in       = SB'(req_word.symbol_in - VB'(1));
                     rank_rd_addr = SB'(req_word.symbol_in - VB'(1));
                     cnt_rd_addr  = SB'(req_word.symbol_in - VB'(1));
                     enc_in       = 1'b1;
                     state_in     = ST_LOOK;
                  end
               end else begin
                  priority case (phase_ff)
                     PH_VALUE: begin
                        acc_in = acc_n;
                        run_in = run_n;
                        if (run_n == '0) begin
                           fin     = 1'b1;
                           fin_val = acc_n;
                        end
                     end
                     PH_WIDE: begin
                        run_in = run_n;
                        if (run_n == '0) begin
                           fin      = 1'b1;
                           fin_wide = 1'b1;
                        end
                     end
                     default: begin
                        phase_in = PH_ZEROS;
                        if (!req_word.code_bit) begin
                           if (run_ff != RB'(argc_pkg::RUN_MAX)) run_in = run_ff + RB'(1);
                        end else if (run_ff == '0) begin
                           fin     = 1'b1;
                           fin_val = VB'(1);
                        end else begin
                           acc_in   = VB'(1);
                           phase_in = (run_ff > RB'(argc_pkg::VALUE_ZEROS_MAX)) ?
                                      PH_WIDE : PH_VALUE;
                        end
                     end
                  endcase
                  if (fin) begin
                     phase_in = PH_ZEROS;
                     run_in   = '0;
                     acc_in   = VB'(1);
                     if (fin_wide || (fin_val == '0) ||
                         ({1'b0, fin_val} > (VB+1)'(argc_pkg::SYMBOLS))) begin
                        emit = 1'b1;
                        rsp_data_in.result_kind    = argc_pkg::KIND_DECODE;
                        rsp_data_in.code_value     = fin_wide ? '0 : fin_val;
                        rsp_data_in.code_length    = fin_wide ? '0 :
                                                     argc_pkg::gamma_len(fin_val);
                        rsp_data_in.decoded_symbol = '0;
                        rsp_data_in.decode_error   = 1'b1;
                     end else begin
                        sym_rd_addr = SB'(fin_val - VB'(1));
                        from_in     = SB'(fin_val - VB'(1));
                        val_in      = fin_val;
                        enc_in      = 1'b0;
                        state_in    = ST_DSYM;
                     end
                  end
               end
            end
         end
         ST_DSYM: begin
            sym_in      = sym_rd_data;
            cnt_rd_addr = sym_rd_data;
            emit = 1'b1;
            rsp_data_in.result_kind    = argc_pkg::KIND_DECODE;
            rsp_data_in.code_value     = val_ff;
            rsp_data_in.code_length    = argc_pkg::gamma_len(val_ff);
            rsp_data_in.decoded_symbol = VB'(sym_rd_data) + VB'(1);
            rsp_data_in.decode_error   = 1'b0;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            c_in = cnt_next;
            if (enc_ff) begin
               from_in = rank_rd_data;
               emit = 1'b1;
               rsp_data_in.result_kind    = argc_pkg::KIND_ENCODE;
               rsp_data_in.code_value     = VB'(rank_rd_data) + VB'(1);
               rsp_data_in.code_length    = argc_pkg::gamma_len(VB'(rank_rd_data) + VB'(1));
               rsp_data_in.decoded_symbol = '0;
               rsp_data_in.decode_error   = 1'b0;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cell_ctl.cmp = 1'b1;
            cnt_wr_en    = 1'b1;
            state_in     = ST_PICK;
         end
         ST_PICK: begin
            // a saturated count that is not above its own cell stays put
            to_in    = argc_pkg::first_index(first);
            any_in   = lt[from_ff];
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (!any_ff) begin
               state_in = ST_IDLE;
            end else begin
               cell_ctl.wr = 1'b1;
               sym_rd_addr = to_ff;
               state_in    = ST_SWAP1;
            end
         end
         ST_SWAP1: begin
            other_in   = sym_rd_data;
            sym_wr_en  = 1'b1;
            rank_wr_en = 1'b1;
            state_in   = ST_SWAP2;
         end
         ST_SWAP2: begin
            sym_wr_en    = 1'b1; sym_wr_addr  = from_ff;  sym_wr_data  = other_ff;
            rank_wr_en   = 1'b1; rank_wr_addr = other_ff; rank_wr_data = from_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= PH_ZEROS;
         run_ff       <= '0;
         acc_ff       <= VB'(1);
         enc_ff       <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         acc_ff       <= acc_in;
         enc_ff       <= enc_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working values and the result word
   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      other_ff    <= other_in;
      c_ff        <= c_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_data_ff;

   // no request is taken during the clearing pass
   `ARGC_ASSERT_ALWAYS(a_clear_stall, (state_ff == ST_CLEAR) |-> req_stall, "request taken while clearing")
   // a new result only lands in a free output register
   `ARGC_ASSERT(a_emit_free, emit |-> (!rsp_valid_ff || !rsp_stall), "result overwrites a waiting word")
   // a symbol only ever moves up the rank list
   `ARGC_ASSERT(a_move_up, ((state_ff == ST_MOVE) && any_ff) |-> (to_ff <= from_ff), "rank moves down")

endmodule
